// ===== hw/rtl/ide_pkg.sv =====
`default_nettype none

package ide_pkg;

   // Field widths
   localparam int CHAR_W   = 8;
   localparam int YEAR_W   = 14;
   localparam int FIELD_W  = 7;
   localparam int POS_W    = 5;
   localparam int GROUPS   = 6;
   localparam int OFFSET_W = 18;
   localparam int TIME_W   = 39;
   localparam int CUM_W    = 12;
   localparam int DIGIT_W  = 4;
   localparam int QUOT_W   = 8;

   // Back-end datapath widths: day count, time of day, day count times 86400
   localparam int DAYS_W   = 25;
   localparam int HMS_W    = 19;
   localparam int PROD_W   = DAYS_W + 18;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;

   // Text positions
   localparam logic [POS_W-1:0] POS_YEAR_END  = 5'd3;
   localparam logic [POS_W-1:0] POS_MONTH_END = 5'd5;
   localparam logic [POS_W-1:0] POS_DAY_END   = 5'd7;
   localparam logic [POS_W-1:0] POS_MARKER    = 5'd8;
   localparam logic [POS_W-1:0] POS_HOUR_END  = 5'd10;
   localparam logic [POS_W-1:0] POS_MIN_END   = 5'd12;
   localparam logic [POS_W-1:0] POS_SEC_END   = 5'd14;
   localparam logic [POS_W-1:0] POS_LIMIT     = 5'd16;

   // Group bits in the stop mask
   localparam int G_YEAR  = 0;
   localparam int G_MONTH = 1;
   localparam int G_DAY   = 2;
   localparam int G_HOUR  = 3;
   localparam int G_MIN   = 4;
   localparam int G_SEC   = 5;

   // Calendar constants
   localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 14'd1970;
   localparam int                LEAPS_1969  = 477;
   localparam int                DAY_SECS    = 86400;
   localparam int                HOUR_SECS   = 3600;
   localparam int                MIN_SECS    = 60;
   localparam int                YEAR_DAYS   = 365;
   localparam int                LONG_MONTHS = 13;
   localparam int                ODD_MONTH   = 30;
   // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT for n below 2^14
   localparam int                RECIP_100   = 5243;
   localparam int                RECIP_SHIFT = 19;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic               short_text;
      logic               all_day;
      logic               add_offset;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_DAYS,
      BK_SUM,
      BK_MUL,
      BK_DONE
   } back_state_type;

   // Days before the first of each month in a common year, months 0 to 13
   localparam logic [CUM_W-1:0] MONTH_START [0:13] = '{
      12'd0, 12'd0, 12'd31, 12'd59, 12'd90, 12'd120, 12'd151,
      12'd181, 12'd212, 12'd243, 12'd273, 12'd304, 12'd334, 12'd365
   };

   function automatic logic [CUM_W-1:0] month_start_days(input logic [FIELD_W-1:0] month);
      logic [CUM_W-1:0] extra;
      extra = CUM_W'(ODD_MONTH) * (CUM_W'(month) - CUM_W'(LONG_MONTHS));
      if (month <= FIELD_W'(LONG_MONTHS)) begin
         return MONTH_START[month[3:0]];
      end else begin
         return CUM_W'(YEAR_DAYS) + extra;
      end
   endfunction

   function automatic logic [YEAR_W-1:0] dec_step(input logic [YEAR_W-1:0] value,
                                                  input logic [DIGIT_W-1:0] digit);
      return YEAR_W'(value * YEAR_W'(10) + YEAR_W'(digit));
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ide_if.sv =====
`default_nettype none

interface ide_req_if;
   logic                     valid;
   logic                     ready;
   logic [ide_pkg::CHAR_W-1:0] text_char;
   logic                     last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface ide_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ide_pkg::TIME_W-1:0] local_time;
   logic                              all_day;

   modport source (output valid, output local_time, output all_day, input ready);
   modport sink   (input valid, input local_time, input all_day, output ready);
endinterface

interface ide_csr_if;
   logic                                valid;
   logic                                ready;
   logic signed [ide_pkg::OFFSET_W-1:0] utc_offset;

   modport source (output valid, output utc_offset, input ready);
   modport sink   (input valid, input utc_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ide_front.sv =====
`default_nettype none

module ide_front (
   input  wire logic             clock,
   input  wire logic             reset,
   ide_req_if.sink               req_bus,
   output logic                  push,
   output ide_pkg::job_type      push_job,
   input  wire logic             push_ready
);
   import ide_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;
   logic [FIELD_W-1:0] day_ff, day_in;
   logic [FIELD_W-1:0] hour_ff, hour_in;
   logic [FIELD_W-1:0] min_ff, min_in;
   logic [FIELD_W-1:0] sec_ff, sec_in;
   logic [GROUPS-1:0]  stop_ff, stop_in;
   logic               mark_ff, mark_in;
   logic               accept;
   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [CHAR_W-1:0]  c;

   assign c        = req_bus.text_char;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign digit    = DIGIT_W'(c - CHAR_ZERO);
   assign accept   = req_bus.valid && push_ready;
   assign req_bus.ready = push_ready;

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      stop_in  = stop_ff;
      mark_in  = mark_ff;
      priority if (pos_ff <= POS_YEAR_END) begin
         if (!stop_ff[G_YEAR]) begin
            if (is_digit) year_in = dec_step(year_ff, digit);
            else stop_in[G_YEAR] = 1'b1;
         end
      end else if (pos_ff <= POS_MONTH_END) begin
         if (!stop_ff[G_MONTH]) begin
            if (is_digit) month_in = FIELD_W'(dec_step(YEAR_W'(month_ff), digit));
            else stop_in[G_MONTH] = 1'b1;
         end
      end else if (pos_ff <= POS_DAY_END) begin
         if (!stop_ff[G_DAY]) begin
            if (is_digit) day_in = FIELD_W'(dec_step(YEAR_W'(day_ff), digit));
            else stop_in[G_DAY] = 1'b1;
         end
      end else if (pos_ff == POS_MARKER) begin
         mark_in = (c == CHAR_T);
      end else if (pos_ff <= POS_HOUR_END) begin
         if (!stop_ff[G_HOUR]) begin
            if (is_digit) hour_in = FIELD_W'(dec_step(YEAR_W'(hour_ff), digit));
            else stop_in[G_HOUR] = 1'b1;
         end
      end else if (pos_ff <= POS_MIN_END) begin
         if (!stop_ff[G_MIN]) begin
            if (is_digit) min_in = FIELD_W'(dec_step(YEAR_W'(min_ff), digit));
            else stop_in[G_MIN] = 1'b1;
         end
      end else if (pos_ff <= POS_SEC_END) begin
         if (!stop_ff[G_SEC]) begin
            if (is_digit) sec_in = FIELD_W'(dec_step(YEAR_W'(sec_ff), digit));
            else stop_in[G_SEC] = 1'b1;
         end
      end else begin
         // past the seconds: characters only count towards the length
      end
      pos_in = (pos_ff < POS_LIMIT) ? pos_ff + 1'b1 : pos_ff;
   end

   // Classify the text on its last beat: length is the current position plus one
   always_comb begin
      push_job.year       = year_in;
      push_job.month      = month_in;
      push_job.day        = day_in;
      push_job.short_text = (pos_ff < POS_DAY_END);
      push_job.all_day    = !push_job.short_text && ((pos_ff == POS_DAY_END) || !mark_in);
      // a date-only text is midnight: drop any time digits
      push_job.hour       = (!push_job.all_day && (pos_ff >= POS_MIN_END)) ? hour_in : '0;
      push_job.minute     = (!push_job.all_day && (pos_ff >= POS_MIN_END)) ? min_in : '0;
      push_job.second     = (!push_job.all_day && (pos_ff >= POS_SEC_END)) ? sec_in : '0;
      push_job.add_offset = !push_job.short_text && !push_job.all_day && (c == CHAR_Z);
   end

   assign push = accept && req_bus.last_char;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff   <= '0;
         year_ff  <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
         stop_ff  <= '0;
         mark_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         stop_ff  <= stop_in;
         mark_ff  <= mark_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ide_fifo.sv =====
`default_nettype none

module ide_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ide_pkg::job_type push_job,
   output logic                  push_ready,
   input  wire logic             pop,
   output logic                  pop_valid,
   output ide_pkg::job_type      pop_job
);
   import ide_pkg::*;

   job_type    slot_ff [0:1];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ide_back.sv =====
`default_nettype none

module ide_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pop_valid,
   input  wire ide_pkg::job_type                    pop_job,
   output logic                                     pop,
   input  wire logic signed [ide_pkg::OFFSET_W-1:0] utc_offset,
   ide_rsp_if.source                                rsp_bus
);
   import ide_pkg::*;

   back_state_type state_ff, state_in;

   job_type                   job_ff;
   logic [QUOT_W-1:0]         qa_ff, qa_in;
   logic [QUOT_W-1:0]         qb_ff, qb_in;
   logic signed [DAYS_W-1:0]  yd_ff, yd_in;
   logic signed [DAYS_W-1:0]  md_ff, md_in;
   logic signed [DAYS_W-1:0]  days_ff, days_in;
   logic [HMS_W-1:0]          hms_ff, hms_in;
   logic signed [TIME_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [TIME_W-1:0]  time_ff, time_in;
   logic                      allday_ff;
   logic                      valid_ff;

   logic [YEAR_W-1:0]         year_m1;
   logic [2*YEAR_W-1:0]       prod_a;
   logic [2*YEAR_W-1:0]       prod_b;
   logic                      leap;
   logic signed [DAYS_W-1:0]  leaps_s;
   logic                      load_out;
   logic                      out_free;

   assign out_free = !valid_ff || rsp_bus.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (pop_valid) state_in = BK_DIV;
         BK_DIV:  state_in = BK_DAYS;
         BK_DAYS: state_in = BK_SUM;
         BK_SUM:  state_in = BK_MUL;
         BK_MUL:  state_in = BK_DONE;
         BK_DONE: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop = pop_valid;
         BK_DONE: load_out = out_free;
         default: begin
            pop      = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // Datapath
   always_comb begin
      year_m1 = job_ff.year - 1'b1;
      prod_a  = (2*YEAR_W)'(year_m1) * (2*YEAR_W)'(RECIP_100);
      prod_b  = (2*YEAR_W)'(job_ff.year) * (2*YEAR_W)'(RECIP_100);
      qa_in   = prod_a[RECIP_SHIFT +: QUOT_W];
      qb_in   = prod_b[RECIP_SHIFT +: QUOT_W];

      leap = (job_ff.year[1:0] == 2'b00) &&
             ((job_ff.year != YEAR_W'(YEAR_W'(qb_ff) * YEAR_W'(100))) ||
              (qb_ff[1:0] == 2'b00));
      leaps_s = $signed(DAYS_W'(year_m1[YEAR_W-1:2])) - $signed(DAYS_W'(qa_ff))
                + $signed(DAYS_W'(qa_ff[QUOT_W-1:2]));
      yd_in = $signed(DAYS_W'(YEAR_DAYS))
              * ($signed(DAYS_W'(job_ff.year)) - $signed(DAYS_W'(EPOCH_YEAR)))
              + leaps_s - $signed(DAYS_W'(LEAPS_1969));
      md_in = $signed(DAYS_W'(month_start_days(job_ff.month)))
              + $signed(DAYS_W'(leap && (job_ff.month >= FIELD_W'(3))))
              + $signed(DAYS_W'(job_ff.day)) - $signed(DAYS_W'(1));

      days_in = yd_ff + md_ff;
      hms_in  = HMS_W'(job_ff.hour) * HMS_W'(HOUR_SECS)
                + HMS_W'(job_ff.minute) * HMS_W'(MIN_SECS) + HMS_W'(job_ff.second);

      prod_in = $signed(PROD_W'(days_ff)) * $signed(PROD_W'(DAY_SECS));

      // Zero the base for short text and for years before the epoch
      if (job_ff.short_text || (job_ff.year < EPOCH_YEAR)) begin
         time_in = '0;
      end else begin
         time_in = prod_ff + $signed(TIME_W'(hms_ff));
      end
      if (job_ff.add_offset) begin
         time_in = time_in + TIME_W'(utc_offset);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= pop_job;
      unique case (state_ff)
         BK_DIV: begin
            qa_ff <= qa_in;
            qb_ff <= qb_in;
         end
         BK_DAYS: begin
            yd_ff <= yd_in;
            md_ff <= md_in;
         end
         BK_SUM: begin
            days_ff <= days_in;
            hms_ff  <= hms_in;
         end
         BK_MUL: prod_ff <= TIME_W'(prod_in);
         default: begin
         end
      endcase
      if (load_out) begin
         time_ff   <= time_in;
         allday_ff <= job_ff.all_day;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) valid_ff <= 1'b1;
         else if (rsp_bus.ready) valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.local_time = time_ff;
   assign rsp_bus.all_day    = allday_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ical_datetime_to_epoch_top.sv =====
// iCalendar date-time text to local epoch seconds.
//
// req_bus carries the text one character a beat (text_char), with last_char
// set on the final beat. Each text ending in a last beat gives exactly one
// rsp_bus beat: local_time, seconds since 1970-01-01 local time, and all_day,
// set for a date-only text. csr_bus writes utc_offset, the seconds added to
// a time marked with a trailing 'Z'; it is always ready, and utc_offset must be
// written only while no text is in flight: the block itself does not enforce this.
//
// The character front end takes one beat per cycle while the job queue has
// room. On the last beat it pushes the parsed fields into a two-entry job
// queue. The epoch back end works through its steps for each text in order
// (pop, quotient by 100, day counts, sum, multiply by 86400, output load) and
// pops the next job only after loading the output. Texts of six or more
// characters stream at one character per cycle while the receiver keeps up;
// shorter texts are limited by the back end once the queue fills.
//
// Reset clears the parser, the queue, the back end and utc_offset. When the
// receiver stalls, the result holds in the output register, the back end
// holds its next result, the queue fills, and then req_bus.ready drops.
`default_nettype none

module ical_datetime_to_epoch_top (
   input  wire logic clock,
   input  wire logic reset,
   ide_req_if.sink   req_bus,
   ide_rsp_if.source rsp_bus,
   ide_csr_if.sink   csr_bus
);
   import ide_pkg::*;

   logic                       push;
   logic                       push_ready;
   job_type                    push_job;
   logic                       pop;
   logic                       pop_valid;
   job_type                    pop_job;
   logic signed [OFFSET_W-1:0] offset_ff;

   // Offset register: always ready, written on each csr beat
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_bus.valid) begin
         offset_ff <= csr_bus.utc_offset;
      end
   end

   ide_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   ide_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   ide_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop),
      .utc_offset (offset_ff),
      .rsp_bus    (rsp_bus)
   );

   // A job is pushed only into a queue with room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("job pushed into full queue");

   // Exactly the last beat of a text pushes a job
   a_push_last: assert property (@(posedge clock) disable iff (reset)
      push == (req_bus.valid && req_bus.ready && req_bus.last_char))
      else $error("job push does not match last beat");

   // Short text is neither all-day nor offset
   a_short_plain: assert property (@(posedge clock) disable iff (reset)
      (push && push_job.short_text) |-> (!push_job.all_day && !push_job.add_offset))
      else $error("short text job carries flags");

   // The back end never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire
